/* rtl/core/rama_pkg.sv */
// Package for the range add/assign array with historical maxima.
// Holds the operation codes, value limits, shared types and defaults.
// No dependencies.
`default_nettype none

package rama_pkg;

  // Payload widths fixed by the item format.
  localparam int FUNC_W          = 3;
  localparam int INDEX_W         = 10;
  localparam int VALUE_W         = 32;
  localparam int ACTIVE_LENGTH_W = 11;

  // One stored entry carries the history above the current value.
  localparam int ENTRY_W = 2 * VALUE_W;

  localparam int DEFAULT_MAX_ELEMENTS = 1024;

  localparam logic [ACTIVE_LENGTH_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_LOAD       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY_CUR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY_HIST = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD        = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN     = 3'd4;

  // Operation of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ASSIGN,
    ALU_QUERY_CUR,
    ALU_QUERY_HIST
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    first;
  } alu_ctrl_t;

endpackage : rama_pkg

`default_nettype wire

/* rtl/core/rama_in_if.sv */
// Input channel: one command word with valid/ready handshake.
// Depends on rama_pkg for the field widths.
`default_nettype none

interface rama_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [rama_pkg::FUNC_W-1:0]            func;
  logic [rama_pkg::INDEX_W-1:0]           range_low;
  logic [rama_pkg::INDEX_W-1:0]           range_high;
  logic signed [rama_pkg::VALUE_W-1:0]    operand_value;

  modport source (
    output valid, func, range_low, range_high, operand_value,
    input  ready
  );

  modport sink (
    input  valid, func, range_low, range_high, operand_value,
    output ready
  );
endinterface : rama_in_if

`default_nettype wire

/* rtl/core/rama_out_if.sv */
// Output channel: one result word with valid/ready handshake.
// Depends on rama_pkg for the field widths.
`default_nettype none

interface rama_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rama_pkg::VALUE_W-1:0] max_value;
  logic                                range_error;

  modport source (
    output valid, max_value, range_error,
    input  ready
  );

  modport sink (
    input  valid, max_value, range_error,
    output ready
  );
endinterface : rama_out_if

`default_nettype wire

/* rtl/core/rama_mem.sv */
// Element store: one write port and one read port with registered read data.
// Each entry holds the historical maximum above the current value.
// Depends on rama_pkg for the entry width.
`default_nettype none

module rama_mem #(
  parameter int DEPTH = rama_pkg::DEFAULT_MAX_ELEMENTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [rama_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [rama_pkg::ENTRY_W-1:0] rd_data
);

  logic [rama_pkg::ENTRY_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule : rama_mem

`default_nettype wire

/* rtl/core/rama_alu.sv */
// Shared arithmetic unit: saturating add or assign with history update,
// or one step of a running maximum for queries.
// Depends on rama_pkg for widths, limits and the control struct.
`default_nettype none

module rama_alu (
  input  wire rama_pkg::alu_ctrl_t                ctrl,
  input  wire logic signed [rama_pkg::VALUE_W-1:0] cur,
  input  wire logic signed [rama_pkg::VALUE_W-1:0] hist,
  input  wire logic signed [rama_pkg::VALUE_W-1:0] operand,
  input  wire logic signed [rama_pkg::VALUE_W-1:0] best,
  output logic signed      [rama_pkg::VALUE_W-1:0] cur_next,
  output logic signed      [rama_pkg::VALUE_W-1:0] hist_next,
  output logic signed      [rama_pkg::VALUE_W-1:0] best_next
);

  logic signed [rama_pkg::VALUE_W:0]   sum;
  logic signed [rama_pkg::VALUE_W-1:0] sat_sum;
  logic signed [rama_pkg::VALUE_W-1:0] probe;

  // The 33-bit sum overflows exactly when its two top bits differ.
  assign sum = {cur[rama_pkg::VALUE_W-1], cur} + {operand[rama_pkg::VALUE_W-1], operand};

  always_comb begin
    if (sum[rama_pkg::VALUE_W] != sum[rama_pkg::VALUE_W-1]) begin
      sat_sum = sum[rama_pkg::VALUE_W] ? rama_pkg::VALUE_MIN : rama_pkg::VALUE_MAX;
    end else begin
      sat_sum = sum[rama_pkg::VALUE_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.op)
      rama_pkg::ALU_ADD:    cur_next = sat_sum;
      rama_pkg::ALU_ASSIGN: cur_next = operand;
      default:              cur_next = cur;
    endcase
    hist_next = (cur_next > hist) ? cur_next : hist;
  end

  always_comb begin
    probe     = (ctrl.op == rama_pkg::ALU_QUERY_HIST) ? hist : cur;
    best_next = (ctrl.first || (probe > best)) ? probe : best;
  end

endmodule : rama_alu

`default_nettype wire

/* rtl/core/range_add_assign_max_history_core.sv */
// Top level of the range add/assign array with historical maxima.
// Depends on rama_pkg, rama_in_if, rama_out_if, rama_mem and rama_alu.
`default_nettype none

// The block keeps MAX_ELEMENTS signed 32-bit values, each with the largest
// value it has ever held, in one on-chip memory whose entries pair the
// current value with its history. A load is written straight through and
// leaves the block ready at once. A range add, range assign or range query
// walks the memory from range_low to range_high, one element per cycle
// through a single read port and a single write port; after the reads the
// block passes a tail state in which the last element returns and, for an
// update, is written back. A query then passes the result state, which
// places its result in the output register and waits there as long as the
// previous result has not been taken. A bad range (low above high, or high
// at or beyond the effective length) sends an update straight back to idle
// and a query straight to the result state, flagged as a range error. The
// element rate is set by the memory ports and the one shared arithmetic
// unit, which does the saturating add, the history update and the running
// maximum. Entries that were never loaded or assigned read back undefined,
// and no clearing pass runs after reset. The length register may be
// written at any time the block is idle; it is not read back.
module range_add_assign_max_history_core #(
  parameter int MAX_ELEMENTS = rama_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [rama_pkg::ACTIVE_LENGTH_W-1:0]   cfg_data,
  rama_in_if.sink                                     item,
  rama_out_if.source                                  result
);

  // Address width of the store, and a width wide enough to hold either the
  // length register or the element count for the range check.
  localparam int AW    = $clog2(MAX_ELEMENTS);
  localparam int LEN_W = ($clog2(MAX_ELEMENTS + 1) > rama_pkg::ACTIVE_LENGTH_W)
                         ? $clog2(MAX_ELEMENTS + 1) : rama_pkg::ACTIVE_LENGTH_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_TAIL,
    S_RESULT
  } state_t;

  state_t state;

  // Configuration and sequencer registers.
  logic [rama_pkg::ACTIVE_LENGTH_W-1:0] active_length;
  logic [AW-1:0]                        idx;
  logic [AW-1:0]                        hi;
  logic [AW-1:0]                        addr_d;
  logic                                 dv;
  logic                                 is_query;
  logic                                 first;
  rama_pkg::alu_op_t                    alu_op;
  logic signed [rama_pkg::VALUE_W-1:0]  operand;
  logic signed [rama_pkg::VALUE_W-1:0]  best;
  logic                                 err;

  // Output register.
  logic                                 result_valid;
  logic signed [rama_pkg::VALUE_W-1:0]  result_value;
  logic                                 result_err;

  // Combinational decode of the incoming word.
  logic              accept;
  logic [LEN_W-1:0]  eff_len;
  logic              bad_range;
  logic              load_ok;

  // Memory and arithmetic unit connections.
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [rama_pkg::ENTRY_W-1:0]  wr_data;
  logic                          rd_en;
  logic [rama_pkg::ENTRY_W-1:0]  rd_data;
  rama_pkg::alu_ctrl_t           alu_ctrl;
  logic signed [rama_pkg::VALUE_W-1:0] cur_next;
  logic signed [rama_pkg::VALUE_W-1:0] hist_next;
  logic signed [rama_pkg::VALUE_W-1:0] best_next;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  // The length in force is the register clipped to the size of the store.
  assign eff_len = (LEN_W'(active_length) < LEN_W'(MAX_ELEMENTS))
                   ? LEN_W'(active_length) : LEN_W'(MAX_ELEMENTS);

  assign bad_range = (item.range_low > item.range_high) ||
                     (LEN_W'(item.range_high) >= eff_len);
  assign load_ok   = (LEN_W'(item.range_low) < eff_len);

  // The walk reads one element a cycle; its data returns in the next cycle and
  // is written back to the same address, which the read side has left.
  assign rd_en = (state == S_SWEEP);

  always_comb begin
    if (accept && (item.func == rama_pkg::FUNC_LOAD)) begin
      wr_en   = load_ok;
      wr_addr = AW'(item.range_low);
      wr_data = {item.operand_value, item.operand_value};
    end else begin
      wr_en   = dv && !is_query;
      wr_addr = addr_d;
      wr_data = {hist_next, cur_next};
    end
  end

  assign alu_ctrl.op    = alu_op;
  assign alu_ctrl.first = first;

  rama_mem #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  rama_alu u_alu (
    .ctrl      (alu_ctrl),
    .cur       (rd_data[rama_pkg::VALUE_W-1:0]),
    .hist      (rd_data[rama_pkg::ENTRY_W-1:rama_pkg::VALUE_W]),
    .operand   (operand),
    .best      (best),
    .cur_next  (cur_next),
    .hist_next (hist_next),
    .best_next (best_next)
  );

  assign result.valid       = result_valid;
  assign result.max_value   = result_value;
  assign result.range_error = result_err;

  // Address of the read now returning; it is where the update goes back.
  always_ff @(posedge clk) begin
    addr_d <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_length <= rama_pkg::ACTIVE_LENGTH_RESET;
      dv            <= 1'b0;
      first         <= 1'b0;
      is_query      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      dv <= rd_en;

      if (cfg_we) begin
        active_length <= cfg_data;
      end

      // A word taken while a new one is being placed is replaced below.
      if (result_valid && result.ready && (state != S_RESULT)) begin
        result_valid <= 1'b0;
      end

      // Fold each returning element into the running maximum.
      if (dv) begin
        first <= 1'b0;
        if (is_query) begin
          best <= best_next;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            idx     <= AW'(item.range_low);
            hi      <= AW'(item.range_high);
            operand <= item.operand_value;
            first   <= 1'b1;
            best    <= '0;
            err     <= bad_range;
            case (item.func)
              rama_pkg::FUNC_QUERY_CUR: begin
                is_query <= 1'b1;
                alu_op   <= rama_pkg::ALU_QUERY_CUR;
                state    <= bad_range ? S_RESULT : S_SWEEP;
              end
              rama_pkg::FUNC_QUERY_HIST: begin
                is_query <= 1'b1;
                alu_op   <= rama_pkg::ALU_QUERY_HIST;
                state    <= bad_range ? S_RESULT : S_SWEEP;
              end
              rama_pkg::FUNC_ADD: begin
                is_query <= 1'b0;
                alu_op   <= rama_pkg::ALU_ADD;
                state    <= bad_range ? S_IDLE : S_SWEEP;
              end
              rama_pkg::FUNC_ASSIGN: begin
                is_query <= 1'b0;
                alu_op   <= rama_pkg::ALU_ASSIGN;
                state    <= bad_range ? S_IDLE : S_SWEEP;
              end
              default: begin
                // Loads are written straight through; unknown codes do nothing.
                is_query <= 1'b0;
                state    <= S_IDLE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          idx <= idx + AW'(1);
          if (idx == hi) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= is_query ? S_RESULT : S_IDLE;
        end
        S_RESULT: begin
          if (!result_valid || result.ready) begin
            result_valid <= 1'b1;
            result_value <= best;
            result_err   <= err;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The write-back always trails the read by one address.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != idx))
    else $error("read and write hit the same element in one cycle");

  // A result appears only from the result state.
  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_RESULT))
    else $error("result raised outside the result state");

  // A walk ends with the tail cycle, whose data is the last element.
  a_tail_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> dv)
    else $error("tail cycle without returning data");

  // Queries never write the store during their walk.
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (dv && is_query) |-> !wr_en)
    else $error("query walk wrote the store");

endmodule : range_add_assign_max_history_core

`default_nettype wire
